### hdl/sqarp_pkg.sv
// Shared types and constants for the square arpeggio voice.
`default_nettype none

package sqarp_pkg;

  localparam int unsigned STEP_W   = 23;
  localparam int unsigned SPN_W    = 16;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned DUTY_W   = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NUM_W    = SPN_W + 1;           // 2*spn fits here
  localparam int unsigned DEN_W    = SPN_W + 1;
  localparam int unsigned DVD_W    = AMP_W + NUM_W;       // amplitude * num
  localparam int unsigned NOTES    = 4;
  localparam int unsigned SLOT_W   = 2;

  localparam logic [STEP_W-1:0]  STEP_FIRST_RST  = STEP_W'(199063);
  localparam logic [STEP_W-1:0]  STEP_SECOND_RST = STEP_W'(250802);
  localparam logic [STEP_W-1:0]  STEP_THIRD_RST  = STEP_W'(298258);
  localparam logic [STEP_W-1:0]  STEP_FOURTH_RST = STEP_W'(398126);
  localparam logic [SPN_W-1:0]   SPN_RST         = SPN_W'(4410);
  localparam logic [TOTAL_W-1:0] TOTAL_RST       = TOTAL_W'(17640);
  localparam logic [AMP_W-1:0]   AMP_RST         = AMP_W'(11200);
  localparam logic [DUTY_W-1:0]  DUTY_RST        = DUTY_W'(4194304);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_FIRST  = 3'd0,
    CFG_STEP_SECOND = 3'd1,
    CFG_STEP_THIRD  = 3'd2,
    CFG_STEP_FOURTH = 3'd3,
    CFG_SPN         = 3'd4,
    CFG_TOTAL       = 3'd5,
    CFG_AMP         = 3'd6,
    CFG_DUTY        = 3'd7
  } cfg_idx_e;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### hdl/sqarp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module sqarp_div
  import sqarp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o,
  output div_stat_t             stat_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   shifted, diff;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    quo_d   = {quo_q[DVD_W-2:0], 1'b0};
    rem_d   = shifted[DEN_W-1:0];
    if (shifted >= {1'b0, divisor_i}) begin
      quo_d[0] = 1'b1;
      rem_d    = diff[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not start");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

### hdl/square_arpeggio_voice.sv
// Top level of the square arpeggio voice: counters, sequencer, output register.
// A request accepted in S_IDLE passes the multiply state S_MUL, the serial divider
// in S_DIV, the done state S_DONE and the load into the output register.
// No new request is taken until the previous result is loaded; a stalled output holds it.
// Reset: asynchronous, active low; config registers take their default values,
// the voice is silent until a restart request, no result is pending.
`default_nettype none

module square_arpeggio_voice
  import sqarp_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 restart_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                      active_o,
  output logic                      last_o
);

  // working widths for compares that must not lose carries
  localparam int unsigned PW = ((PHASE_BITS > DUTY_W) ? PHASE_BITS : DUTY_W) + 1;
  localparam int unsigned XW = ((COUNT_BITS > NUM_W) ? COUNT_BITS : NUM_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]  step_q [NOTES];
  logic [SPN_W-1:0]   spn_q;
  logic [TOTAL_W-1:0] total_q;
  logic [AMP_W-1:0]   amp_q;
  logic [DUTY_W-1:0]  duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q[0] <= STEP_FIRST_RST;
      step_q[1] <= STEP_SECOND_RST;
      step_q[2] <= STEP_THIRD_RST;
      step_q[3] <= STEP_FOURTH_RST;
      spn_q     <= SPN_RST;
      total_q   <= TOTAL_RST;
      amp_q     <= AMP_RST;
      duty_q    <= DUTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_FIRST:  step_q[0] <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_SECOND: step_q[1] <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_THIRD:  step_q[2] <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_FOURTH: step_q[3] <= cfg_data_i[STEP_W-1:0];
        CFG_SPN:         spn_q     <= cfg_data_i[SPN_W-1:0];
        CFG_TOTAL:       total_q   <= cfg_data_i[TOTAL_W-1:0];
        CFG_AMP:         amp_q     <= cfg_data_i[AMP_W-1:0];
        CFG_DUTY:        duty_q    <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Voice state and the per-tick update, done in the accept cycle
  // ---------------------------------------------------------------------------
  state_e                state_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [COUNT_BITS-1:0] done_cnt_q, done_cnt_d;
  logic                  running_q, running_d;

  logic                  accept;
  logic                  run_now;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [SLOT_W-1:0]     slot_cur;
  logic [COUNT_BITS-1:0] tick_cur, done_cur;
  logic [SPN_W-1:0]      spn_eff;
  logic [PW-1:0]         phase_sum;
  logic                  positive;
  logic [XW-1:0]         two_spn_x, tick_x, num_x, tick_inc_x, done_inc_x;
  logic [NUM_W-1:0]      num;
  logic                  is_last;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    // a restart clears the counters before this tick is played
    run_now   = restart_i || running_q;
    phase_cur = restart_i ? '0 : phase_q;
    slot_cur  = restart_i ? '0 : slot_q;
    tick_cur  = restart_i ? '0 : tick_q;
    done_cur  = restart_i ? '0 : done_cnt_q;
    spn_eff   = (spn_q == '0) ? SPN_W'(1) : spn_q;

    phase_sum = PW'(phase_cur) + PW'(step_q[slot_cur]);
    positive  = PW'(phase_sum[PHASE_BITS-1:0]) < PW'(duty_q);

    // note envelope numerator, clamped at zero
    two_spn_x = XW'({spn_eff, 1'b0});
    tick_x    = XW'(tick_cur);
    num_x     = two_spn_x - tick_x;
    num       = (two_spn_x > tick_x) ? num_x[NUM_W-1:0] : '0;

    tick_inc_x = tick_x + XW'(1);
    done_inc_x = XW'(done_cur) + XW'(1);
    is_last    = done_inc_x >= XW'(total_q);

    phase_d    = phase_q;
    slot_d     = slot_q;
    tick_d     = tick_q;
    done_cnt_d = done_cnt_q;
    running_d  = running_q;
    if (accept && run_now) begin
      phase_d = phase_sum[PHASE_BITS-1:0];
      if (tick_inc_x >= XW'(spn_eff)) begin
        tick_d = '0;
        slot_d = (slot_cur == SLOT_W'(NOTES - 1)) ? slot_cur : slot_cur + SLOT_W'(1);
      end else begin
        tick_d = tick_inc_x[COUNT_BITS-1:0];
        slot_d = slot_cur;
      end
      done_cnt_d = done_inc_x[COUNT_BITS-1:0];
      running_d  = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      slot_q     <= '0;
      tick_q     <= '0;
      done_cnt_q <= '0;
      running_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      slot_q     <= slot_d;
      tick_q     <= tick_d;
      done_cnt_q <= done_cnt_d;
      running_q  <= running_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Envelope: amplitude * num / (2 * spn) through the serial divider
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic             pos_q, last_q, act_q;
  logic             div_start;
  logic [DVD_W-1:0] dividend;
  logic [DVD_W-1:0] quotient;
  div_stat_t        div_stat;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q  <= num;
      den_q  <= {spn_eff, 1'b0};
      pos_q  <= positive;
      last_q <= run_now && is_last;
      act_q  <= run_now;
    end
  end

  assign div_start = (state_q == S_MUL);
  assign dividend  = DVD_W'(amp_q) * DVD_W'(num_q);

  sqarp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // magnitude never exceeds amplitude, so the low bits carry it all
  logic [SAMPLE_W-1:0] mag_x, sample_val;

  always_comb begin
    mag_x      = SAMPLE_W'(quotient[AMP_W-1:0]);
    sample_val = pos_q ? mag_x : SAMPLE_W'(0) - mag_x;
    if (!act_q) begin
      sample_val = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                active_q, last_out_q;
  logic                out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      active_q    <= 1'b0;
      last_out_q  <= 1'b0;
    end else begin
      // in S_DONE a leaving result is replaced by the new one below
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            sample_q    <= sample_val;
            active_q    <= act_q;
            last_out_q  <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = signed'(sample_q);
  assign active_o    = active_q;
  assign last_o      = last_out_q;

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> sample_o == '0 && !last_o)
    else $error("silent tick carries a sample or last flag");

  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> active_o)
    else $error("last flag outside the sound");

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !restart_i && running_q && is_last |=> !running_q)
    else $error("voice kept running after its final sample");

  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |=> state_q == S_DIV && div_stat.busy)
    else $error("divider not busy during division");

endmodule

`default_nettype wire
